/* design/skwbm_pkg.sv */
// ----------------------------------------------------------------------------
// skwbm_pkg
// Shared types and constants of the skill window bipartite matcher.
// ----------------------------------------------------------------------------
package skwbm_pkg;

  localparam int unsigned MaxNodesDef  = 128;
  localparam int unsigned SkillBitsDef = 7;

  localparam logic [1:0] OpLoadLeft  = 2'd0;
  localparam logic [1:0] OpLoadRight = 2'd1;
  localparam logic [1:0] OpCompute   = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] skill;
  } in_item_t;

  typedef struct packed {
    logic [7:0] match_count;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic left_we;
    logic right_we;
  } load_req_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_VCLR,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_LSK,
    ST_SCAN,
    ST_CHK,
    ST_VIS,
    ST_AUG,
    ST_AUG_RD,
    ST_AUG_WR,
    ST_POP,
    ST_POP_LD,
    ST_DONE
  } core_state_e;

  function automatic logic can_pair(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= 16'd1;
  endfunction

endpackage

/* design/skwbm_ram.sv */
// ----------------------------------------------------------------------------
// skwbm_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module skwbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/skwbm_core.sv */
// ----------------------------------------------------------------------------
// skwbm_core
// Augmenting-path search engine over node, partner, mark and stack memories.
// ----------------------------------------------------------------------------
module skwbm_core import skwbm_pkg::*; #(
  parameter int unsigned MaxNodes  = MaxNodesDef,
  parameter int unsigned SkillBits = SkillBitsDef,
  localparam int unsigned IdxW = $clog2(MaxNodes),
  localparam int unsigned CntW = IdxW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  load_req_t            load_i,
  input  logic [IdxW-1:0]      load_addr_i,
  input  logic [SkillBits-1:0] load_skill_i,
  input  logic                 start_i,
  input  logic [CntW-1:0]      left_cnt_i,
  input  logic [CntW-1:0]      right_cnt_i,
  input  logic                 take_i,
  output logic                 idle_o,
  output logic                 done_o,
  output logic [7:0]           count_o
);

  localparam int unsigned StkW = IdxW + CntW;

  core_state_e state_q, state_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      u_q, u_d;
  logic [CntW-1:0]      r_q, r_d;
  logic [SkillBits-1:0] su_q, su_d;
  logic [CntW-1:0]      depth_q, depth_d;
  logic [CntW-1:0]      k_q, k_d;
  logic [IdxW-1:0]      w_q, w_d;
  logic                 grew_q, grew_d;
  logic [7:0]           cnt_q, cnt_d;

  logic                 lsk_we, rsk_we;
  logic [IdxW-1:0]      lsk_raddr;
  logic [SkillBits-1:0] lsk_rd, rsk_rd;
  logic                 lp_we, rp_we, vis_we, stk_we;
  logic [IdxW-1:0]      lp_waddr, rp_waddr, vis_waddr, stk_waddr, stk_raddr;
  logic [CntW-1:0]      lp_wdata, rp_wdata, lp_rd, rp_rd;
  logic                 vis_wdata, vis_rd;
  logic [StkW-1:0]      stk_wdata, stk_rd;
  logic [CntW-1:0]      rp_m1, r_p1, u_p1, stk_next, stk_next_m1;
  logic [IdxW-1:0]      stk_node;
  logic                 pair;

  assign rp_m1       = rp_rd - CntW'(1);
  assign r_p1        = r_q + CntW'(1);
  assign u_p1        = {1'b0, u_q} + CntW'(1);
  assign stk_node    = stk_rd[StkW-1:CntW];
  assign stk_next    = stk_rd[CntW-1:0];
  assign stk_next_m1 = stk_next - CntW'(1);
  assign pair        = can_pair(16'(su_q), 16'(rsk_rd));
  assign lsk_we      = load_i.left_we;
  assign rsk_we      = load_i.right_we;

  skwbm_ram #(.Width(SkillBits), .Depth(MaxNodes)) u_lsk (
    .clk_i, .we_i(lsk_we), .waddr_i(load_addr_i), .wdata_i(load_skill_i),
    .raddr_i(lsk_raddr), .rdata_o(lsk_rd)
  );
  skwbm_ram #(.Width(SkillBits), .Depth(MaxNodes)) u_rsk (
    .clk_i, .we_i(rsk_we), .waddr_i(load_addr_i), .wdata_i(load_skill_i),
    .raddr_i(r_q[IdxW-1:0]), .rdata_o(rsk_rd)
  );
  skwbm_ram #(.Width(CntW), .Depth(MaxNodes)) u_lpart (
    .clk_i, .we_i(lp_we), .waddr_i(lp_waddr), .wdata_i(lp_wdata),
    .raddr_i(idx_q[IdxW-1:0]), .rdata_o(lp_rd)
  );
  skwbm_ram #(.Width(CntW), .Depth(MaxNodes)) u_rpart (
    .clk_i, .we_i(rp_we), .waddr_i(rp_waddr), .wdata_i(rp_wdata),
    .raddr_i(r_q[IdxW-1:0]), .rdata_o(rp_rd)
  );
  skwbm_ram #(.Width(1), .Depth(MaxNodes)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .raddr_i(rp_m1[IdxW-1:0]), .rdata_o(vis_rd)
  );
  skwbm_ram #(.Width(StkW), .Depth(MaxNodes)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    u_d     = u_q;
    r_d     = r_q;
    su_d    = su_q;
    depth_d = depth_q;
    k_d     = k_q;
    w_d     = w_q;
    grew_d  = grew_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLR: begin
        if (idx_q == CntW'(MaxNodes - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = ST_VCLR;
        end
      end
      ST_VCLR: begin
        if (idx_q < left_cnt_i) begin
          idx_d = idx_q + CntW'(1);
        end else begin
          idx_d   = '0;
          grew_d  = 1'b0;
          state_d = ST_ROOT_RD;
        end
      end
      ST_ROOT_RD: begin
        if (idx_q >= left_cnt_i) begin
          idx_d   = '0;
          state_d = grew_q ? ST_VCLR : ST_DONE;
        end else begin
          state_d = ST_ROOT_CHK;
        end
      end
      ST_ROOT_CHK: begin
        if (lp_rd == '0) begin
          u_d     = idx_q[IdxW-1:0];
          r_d     = '0;
          depth_d = CntW'(1);
          state_d = ST_LSK;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_ROOT_RD;
        end
      end
      ST_LSK: begin
        su_d    = lsk_rd;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        state_d = (r_q >= right_cnt_i) ? ST_POP : ST_CHK;
      end
      ST_CHK: begin
        if (!pair) begin
          r_d     = r_p1;
          state_d = ST_SCAN;
        end else if (rp_rd == '0) begin
          state_d = ST_AUG;
        end else begin
          w_d     = rp_m1[IdxW-1:0];
          state_d = ST_VIS;
        end
      end
      ST_VIS: begin
        if (!vis_rd && depth_q < CntW'(MaxNodes)) begin
          u_d     = w_q;
          r_d     = '0;
          depth_d = depth_q + CntW'(1);
          state_d = ST_LSK;
        end else begin
          r_d     = r_p1;
          state_d = ST_SCAN;
        end
      end
      ST_AUG: begin
        if (depth_q == CntW'(1)) begin
          grew_d  = 1'b1;
          cnt_d   = cnt_q + 8'd1;
          idx_d   = idx_q + CntW'(1);
          state_d = ST_ROOT_RD;
        end else begin
          k_d     = depth_q - CntW'(2);
          state_d = ST_AUG_RD;
        end
      end
      ST_AUG_RD: begin
        state_d = ST_AUG_WR;
      end
      ST_AUG_WR: begin
        if (k_q == '0) begin
          grew_d  = 1'b1;
          cnt_d   = cnt_q + 8'd1;
          idx_d   = idx_q + CntW'(1);
          state_d = ST_ROOT_RD;
        end else begin
          k_d     = k_q - CntW'(1);
          state_d = ST_AUG_RD;
        end
      end
      ST_POP: begin
        depth_d = depth_q - CntW'(1);
        if (depth_q == CntW'(1)) begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_ROOT_RD;
        end else begin
          state_d = ST_POP_LD;
        end
      end
      ST_POP_LD: begin
        u_d     = stk_node;
        r_d     = stk_next;
        state_d = ST_LSK;
      end
      ST_DONE: begin
        if (take_i) begin
          idx_d   = '0;
          state_d = ST_CLR;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_comb begin
    lp_we     = 1'b0;
    lp_waddr  = idx_q[IdxW-1:0];
    lp_wdata  = '0;
    rp_we     = 1'b0;
    rp_waddr  = idx_q[IdxW-1:0];
    rp_wdata  = '0;
    vis_we    = 1'b0;
    vis_waddr = idx_q[IdxW-1:0];
    vis_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = IdxW'(depth_q - CntW'(1));
    stk_wdata = {u_q, r_p1};
    stk_raddr = IdxW'(depth_q - CntW'(2));
    lsk_raddr = u_q;
    case (state_q)
      ST_CLR: begin
        lp_we = 1'b1;
        rp_we = 1'b1;
      end
      ST_VCLR: vis_we = idx_q < left_cnt_i;
      ST_ROOT_CHK: begin
        lsk_raddr = idx_q[IdxW-1:0];
        if (lp_rd == '0) begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
        end
      end
      ST_VIS: begin
        lsk_raddr = w_q;
        if (!vis_rd && depth_q < CntW'(MaxNodes)) begin
          vis_we    = 1'b1;
          vis_waddr = w_q;
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
        end
      end
      ST_AUG: begin
        lp_we    = 1'b1;
        lp_waddr = u_q;
        lp_wdata = r_p1;
        rp_we    = 1'b1;
        rp_waddr = r_q[IdxW-1:0];
        rp_wdata = u_p1;
      end
      ST_AUG_RD: stk_raddr = k_q[IdxW-1:0];
      ST_AUG_WR: begin
        lp_we    = 1'b1;
        lp_waddr = stk_node;
        lp_wdata = stk_next;
        rp_we    = 1'b1;
        rp_waddr = stk_next_m1[IdxW-1:0];
        rp_wdata = {1'b0, stk_node} + CntW'(1);
      end
      ST_POP_LD: lsk_raddr = stk_node;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      idx_q   <= '0;
      grew_q  <= 1'b0;
      cnt_q   <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      grew_q  <= grew_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    r_q  <= r_d;
    su_q <= su_d;
    k_q  <= k_d;
    w_q  <= w_d;
  end

  assign idle_o  = state_q == ST_IDLE;
  assign done_o  = state_q == ST_DONE;
  assign count_o = cnt_q;

endmodule

/* design/skill_window_bipartite_matching.sv */
// ----------------------------------------------------------------------------
// skill_window_bipartite_matching
// Load items are accepted whenever the core is idle. During a compute item,
// each round sweeps the marks and scans the candidate right nodes one at a
// time, reading the search memories through their registered read ports.
// After reset and after each result the partner memories are cleared,
// during which no item is accepted.
// ----------------------------------------------------------------------------
module skill_window_bipartite_matching import skwbm_pkg::*; #(
  parameter int unsigned MAX_NODES  = MaxNodesDef,
  parameter int unsigned SKILL_BITS = SkillBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = $clog2(MAX_NODES);
  localparam int unsigned CntW = IdxW + 1;

  logic [CntW-1:0]       lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic                  drop_q, drop_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;
  logic                  acc, idle, done, take;
  logic [15:0]           skill_ext;
  logic [SKILL_BITS-1:0] skill;
  logic [IdxW-1:0]       load_addr;
  load_req_t             load;
  logic [7:0]            count;

  assign acc       = in_valid_i && in_ready_o;
  assign in_ready_o = idle;
  assign skill_ext = 16'(in_item_i.skill);
  assign skill     = skill_ext[SKILL_BITS-1:0];
  assign take      = done && (!out_valid_q || out_ready_i);

  always_comb begin
    load.left_we  = acc && in_item_i.opcode == OpLoadLeft && lcnt_q < CntW'(MAX_NODES);
    load.right_we = acc && in_item_i.opcode == OpLoadRight && rcnt_q < CntW'(MAX_NODES);
    load_addr     = (in_item_i.opcode == OpLoadLeft) ? lcnt_q[IdxW-1:0] : rcnt_q[IdxW-1:0];
  end

  skwbm_core #(.MaxNodes(MAX_NODES), .SkillBits(SKILL_BITS)) u_core (
    .clk_i,
    .rst_ni,
    .load_i      (load),
    .load_addr_i (load_addr),
    .load_skill_i(skill),
    .start_i     (acc && in_item_i.opcode == OpCompute),
    .left_cnt_i  (lcnt_q),
    .right_cnt_i (rcnt_q),
    .take_i      (take),
    .idle_o      (idle),
    .done_o      (done),
    .count_o     (count)
  );

  always_comb begin
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (load.left_we) lcnt_d = lcnt_q + CntW'(1);
    if (load.right_we) rcnt_d = rcnt_q + CntW'(1);
    if (acc && (in_item_i.opcode == OpLoadLeft || in_item_i.opcode == OpLoadRight)
        && !load.left_we && !load.right_we) begin
      drop_d = 1'b1;
    end
    if (take) begin
      out_valid_d            = 1'b1;
      out_item_d.match_count = count;
      out_item_d.overflow    = drop_q;
      lcnt_d                 = '0;
      rcnt_d                 = '0;
      drop_d                 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lcnt_q      <= lcnt_d;
      rcnt_q      <= rcnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
